>>> design/ihexp_pkg.sv
// Shared types, constants and helper functions of the Intel HEX record parser.
// Depends on nothing; every other file of the block but ihexp_if imports it.
`default_nettype none

package ihexp_pkg;

    // Characters with a meaning in the record syntax.
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;

    // Record type codes.
    localparam logic [7:0] REC_DATA      = 8'h00;
    localparam logic [7:0] REC_EOF       = 8'h01;
    localparam logic [7:0] REC_EXT_SEG   = 8'h02;
    localparam logic [7:0] REC_START_SEG = 8'h03;
    localparam logic [7:0] REC_EXT_LIN   = 8'h04;
    localparam logic [7:0] REC_START_LIN = 8'h05;

    // Extended address records carry exactly two data bytes.
    localparam logic [7:0] EXT_COUNT = 8'd2;

    // Image span above which the tracking flags the image as too large (128 MiB).
    localparam logic [31:0] TOO_LARGE_LIMIT = 32'h0800_0000;

    // Result kinds.
    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_RECORD = 1'b1;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_FORMAT      = 2'd1,
        ST_CHECKSUM    = 2'd2,
        ST_UNSUPPORTED = 2'd3
    } status_t;

    // Position within a line. Each byte field has a high and a low digit phase,
    // and the high digit phases are the even codes from PH_CNT_H to PH_CK_H.
    typedef enum logic [3:0] {
        PH_LSTART = 4'd0,
        PH_SKIP   = 4'd1,
        PH_CNT_H  = 4'd2,
        PH_CNT_L  = 4'd3,
        PH_AH_H   = 4'd4,
        PH_AH_L   = 4'd5,
        PH_AL_H   = 4'd6,
        PH_AL_L   = 4'd7,
        PH_TY_H   = 4'd8,
        PH_TY_L   = 4'd9,
        PH_DA_H   = 4'd10,
        PH_DA_L   = 4'd11,
        PH_CK_H   = 4'd12,
        PH_CK_L   = 4'd13,
        PH_DONE   = 4'd14
    } phase_t;

    // One result, as it travels to the output register.
    typedef struct packed {
        logic        kind;
        logic [31:0] byte_address;
        logic [7:0]  data_byte;
        logic [7:0]  rec_type;
        status_t     status;
        logic [31:0] low_address;
        logic [31:0] end_address;
        logic        data_present;
        logic        too_large;
    } result_t;

    // Tracking updates requested by a finished record.
    typedef struct packed {
        logic        data_ok;
        logic        eof_ok;
        logic [31:0] start;
        logic [7:0]  count;
    } finish_t;

    // Current tracking state as reported by an EOF record.
    typedef struct packed {
        logic [31:0] low_address;
        logic [31:0] end_address;
        logic        data_present;
        logic        too_large;
    } report_t;

    // Decodes one hex digit in either case; the top bit says whether it was one.
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [7:0] d;
        begin
            d = 8'h00;
            if (c >= 8'h30 && c <= 8'h39)
            begin
                d = c - 8'h30;
                hex_nibble = {1'b1, d[3:0]};
            end
            else if (c >= 8'h41 && c <= 8'h46)
            begin
                d = c - 8'h37;
                hex_nibble = {1'b1, d[3:0]};
            end
            else if (c >= 8'h61 && c <= 8'h66)
            begin
                d = c - 8'h57;
                hex_nibble = {1'b1, d[3:0]};
            end
            else
            begin
                hex_nibble = {1'b0, d[3:0]};
            end
        end
    endfunction

endpackage

`default_nettype wire

>>> design/ihexp_if.sv
// Request channels of the Intel HEX record parser: characters in, results out.
// Independent of the package; widths follow the fixed record syntax.
`default_nettype none

interface ihexp_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;

    modport source (output valid, output character, input ready);
    modport sink   (input valid, input character, output ready);
endinterface

interface ihexp_rec_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [31:0] byte_address;
    logic [7:0]  data_byte;
    logic [7:0]  rec_type;
    logic [1:0]  status;
    logic [31:0] low_address;
    logic [31:0] end_address;
    logic        data_present;
    logic        too_large;

    modport source (output valid, output kind, output byte_address, output data_byte,
                    output rec_type, output status, output low_address,
                    output end_address, output data_present, output too_large,
                    input ready);
    modport sink   (input valid, input kind, input byte_address, input data_byte,
                    input rec_type, input status, input low_address,
                    input end_address, input data_present, input too_large,
                    output ready);
endinterface

`default_nettype wire

>>> design/ihexp_track.sv
// Lowest start and highest end address tracking across data records.
// Depends on ihexp_pkg for the finish and report structs.
`default_nettype none

module ihexp_track
    import ihexp_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire finish_t finish,
    output report_t      report
);

    logic [31:0] min_start_reg, min_start_next;
    logic [31:0] max_end_reg, max_end_next;
    logic        seen_data_reg, seen_data_next;
    logic [31:0] end_addr;
    logic [31:0] span;

    assign end_addr = finish.start + {24'h0, finish.count};
    assign span     = max_end_reg - min_start_reg;

    always_comb
    begin
        min_start_next = min_start_reg;
        max_end_next   = max_end_reg;
        seen_data_next = seen_data_reg;
        if (finish.data_ok)
        begin
            seen_data_next = 1'b1;
            if (finish.start < min_start_reg)
            begin
                min_start_next = finish.start;
            end
            if (end_addr > max_end_reg)
            begin
                max_end_next = end_addr;
            end
        end
        else if (finish.eof_ok)
        begin
            min_start_next = '1;
            max_end_next   = '0;
            seen_data_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_start_reg <= '1;
            max_end_reg   <= '0;
            seen_data_reg <= 1'b0;
        end
        else
        begin
            min_start_reg <= min_start_next;
            max_end_reg   <= max_end_next;
            seen_data_reg <= seen_data_next;
        end
    end

    // The report shows the state before an EOF record clears it.
    assign report.low_address  = min_start_reg;
    assign report.end_address  = max_end_reg;
    assign report.data_present = seen_data_reg;
    assign report.too_large    = seen_data_reg && (span > TOO_LARGE_LIMIT);

endmodule

`default_nettype wire

>>> design/ihexp_core.sv
// Line parser of the Intel HEX record parser: one character per step.
// Depends on ihexp_pkg for phases, codes and the nibble decoder.
`default_nettype none

module ihexp_core
    import ihexp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step,
    input  wire logic [7:0] character,
    input  wire report_t    report,
    output finish_t         finish,
    output logic            res_valid,
    output result_t         result
);

    phase_t      phase_reg, phase_next;
    logic [3:0]  high_nibble_reg, high_nibble_next;
    logic [7:0]  byte_index_reg, byte_index_next;
    logic [7:0]  count_reg, count_next;
    logic [7:0]  running_sum_reg, running_sum_next;
    logic [7:0]  offset_hi_reg, offset_hi_next;
    logic [31:0] start_address_reg, start_address_next;
    logic [7:0]  type_code_reg, type_code_next;
    logic [15:0] extension_reg, extension_next;
    logic [31:0] base_address_reg, base_address_next;

    logic [4:0]  nib;
    logic [7:0]  byte_val;
    logic [7:0]  sum_plus;
    logic [7:0]  index_inc;
    logic        eol;

    assign nib       = hex_nibble(character);
    assign byte_val  = {high_nibble_reg, nib[3:0]};
    assign sum_plus  = running_sum_reg + byte_val;
    assign index_inc = byte_index_reg + 8'd1;
    assign eol       = (character == CHAR_CR) || (character == CHAR_LF);

    always_comb
    begin
        phase_next         = phase_reg;
        high_nibble_next   = high_nibble_reg;
        byte_index_next    = byte_index_reg;
        count_next         = count_reg;
        running_sum_next   = running_sum_reg;
        offset_hi_next     = offset_hi_reg;
        start_address_next = start_address_reg;
        type_code_next     = type_code_reg;
        extension_next     = extension_reg;
        base_address_next  = base_address_reg;
        res_valid          = 1'b0;
        result             = '0;
        finish.data_ok     = 1'b0;
        finish.eof_ok      = 1'b0;
        finish.start       = start_address_reg;
        finish.count       = count_reg;

        if (step)
        begin
            case (phase_reg)
                PH_LSTART:
                begin
                    if (character == CHAR_COLON)
                    begin
                        high_nibble_next   = '0;
                        byte_index_next    = '0;
                        count_next         = '0;
                        running_sum_next   = '0;
                        offset_hi_next     = '0;
                        start_address_next = base_address_reg;
                        type_code_next     = '0;
                        extension_next     = '0;
                        phase_next         = PH_CNT_H;
                    end
                    else if (!eol)
                    begin
                        phase_next = PH_SKIP;
                    end
                end
                PH_CNT_H, PH_CNT_L, PH_AH_H, PH_AH_L, PH_AL_H, PH_AL_L,
                PH_TY_H, PH_TY_L, PH_DA_H, PH_DA_L, PH_CK_H, PH_CK_L:
                begin
                    if (eol || !nib[4])
                    begin
                        // A short line starts afresh; a bad digit drops the rest of it.
                        phase_next      = eol ? PH_LSTART : PH_DONE;
                        res_valid       = 1'b1;
                        result.kind     = KIND_RECORD;
                        result.rec_type = type_code_reg;
                        result.status   = ST_FORMAT;
                    end
                    else if (!phase_reg[0])
                    begin
                        high_nibble_next = nib[3:0];
                        phase_next       = phase_t'(phase_reg + 4'd1);
                    end
                    else
                    begin
                        running_sum_next = sum_plus;
                        case (phase_reg)
                            PH_CNT_L:
                            begin
                                count_next = byte_val;
                                phase_next = PH_AH_H;
                            end
                            PH_AH_L:
                            begin
                                offset_hi_next = byte_val;
                                phase_next     = PH_AL_H;
                            end
                            PH_AL_L:
                            begin
                                start_address_next = base_address_reg
                                                   + {16'h0, offset_hi_reg, byte_val};
                                phase_next         = PH_TY_H;
                            end
                            PH_TY_L:
                            begin
                                type_code_next = byte_val;
                                phase_next     = (count_reg != 8'd0) ? PH_DA_H : PH_CK_H;
                            end
                            PH_DA_L:
                            begin
                                if (type_code_reg == REC_DATA)
                                begin
                                    res_valid           = 1'b1;
                                    result.kind         = KIND_DATA;
                                    result.byte_address = start_address_reg
                                                        + {24'h0, byte_index_reg};
                                    result.data_byte    = byte_val;
                                end
                                if (byte_index_reg == 8'd0)
                                begin
                                    extension_next = {byte_val, 8'h00};
                                end
                                else if (byte_index_reg == 8'd1)
                                begin
                                    extension_next = {extension_reg[15:8], byte_val};
                                end
                                byte_index_next = index_inc;
                                phase_next      = (index_inc == count_reg) ? PH_CK_H : PH_DA_H;
                            end
                            default:
                            begin
                                // Checksum low digit: the record is complete.
                                phase_next      = PH_DONE;
                                res_valid       = 1'b1;
                                result.kind     = KIND_RECORD;
                                result.rec_type = type_code_reg;
                                result.status   = ST_OK;
                                if (sum_plus != 8'h00)
                                begin
                                    result.status = ST_CHECKSUM;
                                end
                                else
                                begin
                                    case (type_code_reg)
                                        REC_DATA:
                                        begin
                                            finish.data_ok = 1'b1;
                                        end
                                        REC_EOF:
                                        begin
                                            finish.eof_ok       = 1'b1;
                                            result.low_address  = report.low_address;
                                            result.end_address  = report.end_address;
                                            result.data_present = report.data_present;
                                            result.too_large    = report.too_large;
                                        end
                                        REC_EXT_SEG:
                                        begin
                                            if (count_reg != EXT_COUNT)
                                            begin
                                                result.status = ST_FORMAT;
                                            end
                                            else
                                            begin
                                                base_address_next = {12'h0, extension_reg, 4'h0};
                                            end
                                        end
                                        REC_EXT_LIN:
                                        begin
                                            if (count_reg != EXT_COUNT)
                                            begin
                                                result.status = ST_FORMAT;
                                            end
                                            else
                                            begin
                                                base_address_next = {extension_reg, 16'h0};
                                            end
                                        end
                                        REC_START_SEG, REC_START_LIN:
                                        begin
                                            result.status = ST_OK;
                                        end
                                        default:
                                        begin
                                            result.status = ST_UNSUPPORTED;
                                        end
                                    endcase
                                end
                            end
                        endcase
                    end
                end
                default:
                begin
                    // Skipped lines and the tail after a checksum wait for the line end.
                    if (eol)
                    begin
                        phase_next = PH_LSTART;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_LSTART;
            high_nibble_reg   <= '0;
            byte_index_reg    <= '0;
            count_reg         <= '0;
            running_sum_reg   <= '0;
            offset_hi_reg     <= '0;
            start_address_reg <= '0;
            type_code_reg     <= '0;
            extension_reg     <= '0;
            base_address_reg  <= '0;
        end
        else
        begin
            phase_reg         <= phase_next;
            high_nibble_reg   <= high_nibble_next;
            byte_index_reg    <= byte_index_next;
            count_reg         <= count_next;
            running_sum_reg   <= running_sum_next;
            offset_hi_reg     <= offset_hi_next;
            start_address_reg <= start_address_next;
            type_code_reg     <= type_code_next;
            extension_reg     <= extension_next;
            base_address_reg  <= base_address_next;
        end
    end

endmodule

`default_nettype wire

>>> design/intel_hex_record_parser.sv
// Intel HEX record parser, top level: input register, parser, tracking, result register.
// The parse step moves a character from the input register through the parser; any
// result that it yields is registered in the result register for the consumer.
// Throughput: one character per cycle, set by the parse step; a stalled result
// register holds the step back.
// Reset (rst_n, asynchronous, active low) empties both registers, returns the parser to
// line start and sets the lowest tracked address to all ones.
`default_nettype none

module intel_hex_record_parser
    import ihexp_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    ihexp_char_if.sink  char_stream,
    ihexp_rec_if.source records
);

    // Input register: holds one character request until the parser takes it.
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_char_reg, in_char_next;

    // Result register: holds one result request until the consumer takes it.
    logic       out_valid_reg, out_valid_next;
    result_t    out_data_reg, out_data_next;

    logic       step;
    logic       res_valid;
    result_t    result;
    finish_t    finish;
    report_t    report;

    // The parser advances whenever the result register is empty or is being emptied in
    // this cycle; a result that waits on a stalled consumer holds every character back.
    assign step              = in_valid_reg && (!out_valid_reg || records.ready);
    assign char_stream.ready = !in_valid_reg || step;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        in_char_next  = in_char_reg;
        if (char_stream.valid && char_stream.ready)
        begin
            in_valid_next = 1'b1;
            in_char_next  = char_stream.character;
        end
        else if (step)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (step && res_valid)
        begin
            out_valid_next = 1'b1;
            out_data_next  = result;
        end
        else if (records.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset; their valid bits guard them.
    always_ff @(posedge clk)
    begin
        in_char_reg  <= in_char_next;
        out_data_reg <= out_data_next;
    end

    ihexp_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .character (in_char_reg),
        .report    (report),
        .finish    (finish),
        .res_valid (res_valid),
        .result    (result)
    );

    ihexp_track u_track (
        .clk    (clk),
        .rst_n  (rst_n),
        .finish (finish),
        .report (report)
    );

    assign records.valid        = out_valid_reg;
    assign records.kind         = out_data_reg.kind;
    assign records.byte_address = out_data_reg.byte_address;
    assign records.data_byte    = out_data_reg.data_byte;
    assign records.rec_type     = out_data_reg.rec_type;
    assign records.status       = out_data_reg.status;
    assign records.low_address  = out_data_reg.low_address;
    assign records.end_address  = out_data_reg.end_address;
    assign records.data_present = out_data_reg.data_present;
    assign records.too_large    = out_data_reg.too_large;

    // A result waiting on a stalled consumer must hold the parser still.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !records.ready |-> !step)
        else $error("parser stepped while the result register was stalled");

    // Every result that the parser produces reaches the result register.
    assert property (@(posedge clk) disable iff (!rst_n)
        step && res_valid |=> out_valid_reg)
        else $error("parser result was not captured");

    // A character request waiting in the input register stays until parsed.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !step |=> in_valid_reg && $stable(in_char_reg))
        else $error("pending character was lost");

    // Tracking may change only on a step that finishes a record.
    assert property (@(posedge clk) disable iff (!rst_n)
        (finish.data_ok || finish.eof_ok) |-> step && res_valid)
        else $error("tracking update without a record result");

endmodule

`default_nettype wire
